// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the pair sum index finder checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSIF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psif check failed");

// next-cycle implication
`define PSIF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psif check failed");

`endif

// File: design/psif_pkg.sv
// ----------------------------------------------------------------------------
// psif_pkg
// shared constants, types and helpers of the pair sum index finder
// ----------------------------------------------------------------------------
package psif_pkg;

   localparam int MAX_ITEMS   = 128;
   localparam int VALUE_BITS  = 32;
   localparam int DATA_BITS   = 32;
   localparam int INDEX_BITS  = 7;
   localparam int STATUS_BITS = 2;
   localparam int KEY_BITS    = ((VALUE_BITS > DATA_BITS) ? VALUE_BITS : DATA_BITS) + 1;
   localparam int POS_BITS    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // one stored element of the set
   typedef struct packed {
      logic                         valid;
      logic signed [VALUE_BITS-1:0] value;
      logic [POS_BITS-1:0]          pos;
   } entry_type;

   // lookup token walking down the row
   typedef struct packed {
      logic                       valid;
      logic signed [KEY_BITS-1:0] key;
      logic                       hit;
      logic [POS_BITS-1:0]        pos;
   } query_type;

   // row-wide controls
   typedef struct packed {
      logic shift_en;
      logic clear;
   } ctrl_type;

   // low VALUE_BITS of the port, sign extended
   function automatic logic signed [VALUE_BITS-1:0] sext_value(input logic [DATA_BITS-1:0] raw);
      logic signed [KEY_BITS-1:0] wide;
      wide = KEY_BITS'($signed(raw));
      return wide[VALUE_BITS-1:0];
   endfunction

endpackage

// File: design/psif_cell.sv
// ----------------------------------------------------------------------------
// psif_cell
// one storage cell: holds an element, compares the passing lookup token
// ----------------------------------------------------------------------------
module psif_cell
   import psif_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  ctrl_type  ctrl,
   input  entry_type entry_in,
   output entry_type entry_out,
   input  query_type query_in,
   output query_type query_out
);

   entry_type entry_ff;
   query_type query_ff;
   query_type query_in_next;
   logic      match;

   assign match = query_in.valid && !query_in.hit && entry_ff.valid &&
                  (KEY_BITS'(entry_ff.value) == query_in.key);

   always_comb begin
      query_in_next = query_in;
      if (match) begin
         query_in_next.hit = 1'b1;
         query_in_next.pos = entry_ff.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         entry_ff.valid <= 1'b0;
      end else if (ctrl.shift_en) begin
         entry_ff.valid <= entry_in.valid;
      end
      if (ctrl.shift_en) begin
         entry_ff.value <= entry_in.value;
         entry_ff.pos   <= entry_in.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff.valid <= 1'b0;
      end else begin
         query_ff.valid <= query_in_next.valid;
      end
      query_ff.key <= query_in_next.key;
      query_ff.hit <= query_in_next.hit;
      query_ff.pos <= query_in_next.pos;
   end

   assign entry_out = entry_ff;
   assign query_out = query_ff;

endmodule

// File: design/psif_chain.sv
// ----------------------------------------------------------------------------
// psif_chain
// row of storage cells; newest element at the head, lookups walk to the tail
// ----------------------------------------------------------------------------
module psif_chain
   import psif_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  ctrl_type  ctrl,
   input  entry_type head_entry,
   input  query_type head_query,
   output query_type tail_query
);

   entry_type entry_link [MAX_ITEMS];
   query_type query_link [MAX_ITEMS+1];

   assign entry_link[0] = head_entry;
   assign query_link[0] = head_query;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      if (i < MAX_ITEMS - 1) begin : g_mid
         psif_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .entry_in  (entry_link[i]),
            .entry_out (entry_link[i+1]),
            .query_in  (query_link[i]),
            .query_out (query_link[i+1])
         );
      end else begin : g_end
         // oldest slot; its element never moves further
         psif_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .entry_in  (entry_link[i]),
            .entry_out (),
            .query_in  (query_link[i]),
            .query_out (query_link[i+1])
         );
      end
   end

   assign tail_query = query_link[MAX_ITEMS];

endmodule

// File: design/pair_sum_index_finder_core.sv
// ----------------------------------------------------------------------------
// pair_sum_index_finder_core
// streaming two-sum: finds the first pair of a set that reaches the target
// ----------------------------------------------------------------------------
//
//   channel   ports                                   direction  handshake
//   request   start, req_value, req_last_of_set       in         start & !busy
//   result    rsp_valid, rsp_status, rsp_*_index      out        rsp_valid strobe
//   csr       csr_write_enable, csr_write_data        in         write enable
//
// a request that needs a lookup holds busy until the lookup token leaves the row:
//   the lookup token passes through every cell of the row, one per cycle
// a request after a pair, or after the store has filled, needs no lookup and never raises busy
// the result strobe of a lookup rises in the cycle after the lookup leaves the row
// synchronous active-high reset clears the control state and all valid bits
// results are never held off, so the block never waits on the receiver
//
module pair_sum_index_finder_core
   import psif_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [DATA_BITS-1:0]   req_value,
   input  logic                   req_last_of_set,
   // result channel
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [INDEX_BITS-1:0]  rsp_first_index,
   output logic [INDEX_BITS-1:0]  rsp_second_index,
   // target register
   input  logic                   csr_write_enable,
   input  logic [DATA_BITS-1:0]   csr_write_data
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // control state
   state_type                    state_ff,     state_in;
   logic [COUNT_BITS-1:0]        count_ff,     count_in;
   logic                         pair_ff,      pair_in;
   logic                         ovf_ff,       ovf_in;
   logic [DATA_BITS-1:0]         target_ff;
   // current request
   logic signed [VALUE_BITS-1:0] value_ff,     value_in;
   logic                         last_ff,      last_in;
   query_type                    launch_ff,    launch_in;
   // registered result
   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   status_ff,    status_in;
   logic [INDEX_BITS-1:0]        first_ff,     first_in;
   logic [INDEX_BITS-1:0]        second_ff,    second_in;

   logic                         accept;
   logic signed [VALUE_BITS-1:0] req_sext;
   ctrl_type                     row_ctrl;
   entry_type                    head_entry;
   query_type                    tail_query;

   assign accept   = start && (state_ff == ST_IDLE);
   assign req_sext = sext_value(req_value);

   // new element enters at the head, tagged with its position in the set
   always_comb begin
      head_entry.valid = 1'b1;
      head_entry.value = value_ff;
      head_entry.pos   = count_ff[POS_BITS-1:0];
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      pair_in           = pair_ff;
      ovf_in            = ovf_ff;
      value_in          = value_ff;
      last_in           = last_ff;
      launch_in         = launch_ff;
      launch_in.valid   = 1'b0;
      rsp_valid_in      = 1'b0;
      status_in         = status_ff;
      first_in          = first_ff;
      second_in         = second_ff;
      row_ctrl.shift_en = 1'b0;
      row_ctrl.clear    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_sext;
               last_in  = req_last_of_set;
               if (pair_ff || ovf_ff || (count_ff == COUNT_BITS'(MAX_ITEMS))) begin
                  // set already settled or store full: no lookup
                  if (!pair_ff) begin
                     ovf_in = 1'b1;
                  end
                  if (req_last_of_set) begin
                     if (!pair_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_OVERFLOW;
                        first_in     = '0;
                        second_in    = '0;
                     end
                     count_in       = '0;
                     pair_in        = 1'b0;
                     ovf_in         = 1'b0;
                     row_ctrl.clear = 1'b1;
                  end
               end else begin
                  // key is exact: target minus value in one extra bit
                  launch_in.valid = 1'b1;
                  launch_in.key   = KEY_BITS'($signed(target_ff)) - KEY_BITS'(req_sext);
                  launch_in.hit   = 1'b0;
                  launch_in.pos   = '0;
                  state_in        = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (tail_query.valid) begin
               if (tail_query.hit) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_FOUND;
                  first_in     = INDEX_BITS'(tail_query.pos);
                  second_in    = INDEX_BITS'(count_ff);
                  pair_in      = 1'b1;
               end else begin
                  row_ctrl.shift_en = 1'b1;
                  count_in          = count_ff + 1'b1;
               end
               if (last_ff) begin
                  if (!tail_query.hit) begin
                     rsp_valid_in = 1'b1;
                     status_in    = STATUS_NONE;
                     first_in     = '0;
                     second_in    = '0;
                  end
                  // clear wins over the shift inside each cell
                  count_in       = '0;
                  pair_in        = 1'b0;
                  ovf_in         = 1'b0;
                  row_ctrl.clear = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         pair_ff         <= 1'b0;
         ovf_ff          <= 1'b0;
         target_ff       <= '0;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         pair_ff         <= pair_in;
         ovf_ff          <= ovf_in;
         launch_ff.valid <= launch_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_write_enable) begin
            target_ff <= csr_write_data;
         end
      end
      // payload
      value_ff      <= value_in;
      last_ff       <= last_in;
      launch_ff.key <= launch_in.key;
      launch_ff.hit <= launch_in.hit;
      launch_ff.pos <= launch_in.pos;
      status_ff     <= status_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
   end

   // storage row: newest element at cell 0, lookup walks toward the oldest
   psif_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (row_ctrl),
      .head_entry (head_entry),
      .head_query (launch_ff),
      .tail_query (tail_query)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_first_index  = first_ff;
   assign rsp_second_index = second_ff;

endmodule

// File: design/psif_checker.sv
// ----------------------------------------------------------------------------
// psif_checker
// port-level checks on the pair sum index finder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psif_checker
   import psif_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [INDEX_BITS-1:0]  rsp_first_index,
   input logic [INDEX_BITS-1:0]  rsp_second_index
);

   logic rsp_no_pair;
   logic idx_clear;

   assign rsp_no_pair = rsp_valid && (rsp_status != STATUS_FOUND);
   assign idx_clear   = (rsp_first_index == '0) && (rsp_second_index == '0);

   // reset leaves the block idle with no result pending
   `PSIF_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !busy && !rsp_valid)

   // only a found pair carries indices
   `PSIF_ASSERT_IMP(a_idx_zero, clock, reset, rsp_no_pair, idx_clear)

   // a lookup only starts from an accepted request
   `PSIF_ASSERT_IMP(a_busy_cause, clock, reset, $rose(busy), $past(start && !busy))

   // a result after an idle cycle comes from the request accepted then
   `PSIF_ASSERT_IMP(a_rsp_cause, clock, reset, rsp_valid && !$past(busy), $past(start))

endmodule

bind pair_sum_index_finder_core psif_checker u_psif_checker (.*);

// File: bench/pair_sum_index_finder_core_tb.sv
// ----------------------------------------------------------------------------
// pair_sum_index_finder_core_tb
// self-checking bench for the streaming two-sum core: a scoreboard predicts
// the outcome of every set from the requests the core accepts and checks
// each result strobe in order, over directed corner sets and random sets
// under several target settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pair_sum_index_finder_core_tb;
   import psif_pkg::*;

   // generous watchdog: every lookup walks its token through the whole row of cells
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int PHASE_ITEMS   = 200;
   // the core may still be walking a lookup when the last result has come
   localparam int SETTLE_CYCLES = MAX_ITEMS + 8;

   // value mix of a random set
   localparam int MODE_SMALL = 0;
   localparam int MODE_FULL  = 1;
   localparam int MODE_LONG  = 2;

   typedef struct {
      status_type             status;
      logic [INDEX_BITS-1:0]  first_index;
      logic [INDEX_BITS-1:0]  second_index;
   } outcome_type;

   // --------------------------------------------------------------------------
   // scoreboard: its own copy of the store, the set state and the target
   // --------------------------------------------------------------------------
   class pair_search_scoreboard;
      logic signed [VALUE_BITS-1:0] stored_value [MAX_ITEMS];
      int unsigned                  fill;
      bit                           pair_seen;
      bit                           overflowed;
      logic signed [DATA_BITS-1:0]  target;
      outcome_type                  expected_outcomes [$];
      int                           errors;
      int                           requests;
      int                           seen_by_status [3];

      function new();
         target = '0;
         errors = 0;
         requests = 0;
         seen_by_status = '{0, 0, 0};
         clear_set();
      endfunction

      function void clear_set();
         fill = 0;
         pair_seen = 1'b0;
         overflowed = 1'b0;
      endfunction

      function void set_target(logic [DATA_BITS-1:0] t);
         target = $signed(t);
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void queue_outcome(outcome_type o);
         expected_outcomes.insert(expected_outcomes.size(), o);
      endfunction

      function void note_request(logic [DATA_BITS-1:0] raw, bit last);
         logic signed [VALUE_BITS-1:0] v;
         outcome_type                  o;
         bit                           hit;
         bit                           produced;
         int                           k;
         int                           pos;
         v = $signed(raw[VALUE_BITS-1:0]);
         produced = 1'b0;
         hit = 1'b0;
         pos = 0;
         requests++;
         if (!pair_seen && !overflowed) begin
            if (fill >= MAX_ITEMS) begin
               overflowed = 1'b1;
            end else begin
               // newest matching cell wins; the sum is taken exactly
               for (k = int'(fill) - 1; k >= 0; k--) begin
                  if (longint'(stored_value[k]) + longint'(v) == longint'(target)) begin
                     hit = 1'b1;
                     pos = k;
                     break;
                  end
               end
               if (hit) begin
                  o.status = STATUS_FOUND;
                  o.first_index = pos[INDEX_BITS-1:0];
                  o.second_index = fill[INDEX_BITS-1:0];
                  queue_outcome(o);
                  produced = 1'b1;
                  pair_seen = 1'b1;
               end else begin
                  stored_value[fill] = v;
                  fill++;
               end
            end
         end
         if (last) begin
            if (!produced && !pair_seen) begin
               o.status = overflowed ? STATUS_OVERFLOW : STATUS_NONE;
               o.first_index = '0;
               o.second_index = '0;
               queue_outcome(o);
            end
            clear_set();
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t ns  mismatch: %s", $time, msg);
      endtask

      task check_result(logic [STATUS_BITS-1:0] st, logic [INDEX_BITS-1:0] fi,
                        logic [INDEX_BITS-1:0] si);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: status %0d first %0d second %0d",
                                      st, fi, si));
         end else begin
            want = expected_outcomes.pop_front();
            seen_by_status[want.status]++;
            if (st !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (fi !== want.first_index)
               report_mismatch($sformatf("first_index %0d, want %0d", fi, want.first_index));
            if (si !== want.second_index)
               report_mismatch($sformatf("second_index %0d, want %0d", si, want.second_index));
         end
      endtask
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and the ports of the core
   // --------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [DATA_BITS-1:0]   req_value = '0;
   logic                   req_last_of_set = 1'b0;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [INDEX_BITS-1:0]  rsp_first_index;
   logic [INDEX_BITS-1:0]  rsp_second_index;
   logic                   csr_write_enable = 1'b0;
   logic [DATA_BITS-1:0]   csr_write_data = '0;

   pair_search_scoreboard  sb;
   logic [DATA_BITS-1:0]   set_values [$];
   int                     cycle_count = 0;
   int                     counted_items = 0;
   int                     targets_written = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pair_sum_index_finder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_of_set  (req_last_of_set),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // results last one cycle and cannot be held off: sample every edge,
   // reading the values that stood before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_first_index, rsp_second_index);
   end

   // watchdog on a hung core or a lost result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
         $display("pair_sum_index_finder_core_tb: done, errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------

   // present one request, hold it until start & !busy at an edge, then
   // optionally drop start for a gap of idle cycles
   task automatic send_item(logic [DATA_BITS-1:0] v, bit last, int gap);
      start <= 1'b1;
      req_value <= v;
      req_last_of_set <= last;
      do @(posedge clock); while (busy);
      sb.note_request(v, last);
      counted_items++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // target only changes with the core idle: nothing pending, not busy,
   // and a full lookup walk of slack for requests that give no result
   task automatic write_target(logic [DATA_BITS-1:0] t);
      start <= 1'b0;
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= t;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_target(t);
      targets_written++;
   endtask

   function automatic int idle_gap();
      return $urandom_range(0, 11);
   endfunction

   // value that completes the target with an earlier value, when it fits
   function automatic logic [DATA_BITS-1:0] partner_of(logic [DATA_BITS-1:0] earlier);
      longint want;
      want = longint'(sb.target) - longint'($signed(earlier));
      if (want == longint'($signed(want[DATA_BITS-1:0])))
         return want[DATA_BITS-1:0];
      return $urandom();
   endfunction

   function automatic logic [DATA_BITS-1:0] fresh_value(int mode);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // extremes of the signed range, zero and minus one
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (mode == MODE_SMALL)
         return DATA_BITS'($signed($urandom_range(0, 120)) - 60);
      return $urandom();
   endfunction

   // one set of requests; after a pair most sets jump to their last request
   task automatic run_set(int len, int mode, bit burst);
      int                   i;
      logic [DATA_BITS-1:0] v;
      set_values.delete();
      i = 0;
      while (i < len) begin
         if (mode == MODE_LONG) begin
            // long sets are random and wide, with maybe one pair at the top cell
            v = $urandom();
            if (i == MAX_ITEMS - 1 && $urandom_range(0, 1) == 1)
               v = partner_of(set_values[5]);
         end else if (i > 0 && $urandom_range(0, 99) < 30) begin
            v = partner_of(set_values[$urandom_range(0, set_values.size() - 1)]);
         end else begin
            v = fresh_value(mode);
         end
         set_values.insert(set_values.size(), v);
         send_item(v, i == len - 1, burst ? 0 : idle_gap());
         if (sb.pair_seen && i + 2 < len && $urandom_range(0, 2) != 0)
            i = len - 1;
         else
            i++;
      end
   endtask

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      logic [DATA_BITS-1:0] phase_targets [8];
      int                   phase;
      int                   phase_start;
      int                   mode;

      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, target at its reset value of zero
      send_item(32'd5, 1'b0, idle_gap());            // pair lands on the last request
      send_item(32'hFFFF_FFFB, 1'b1, idle_gap());
      send_item(32'd0, 1'b1, idle_gap());            // half the target, no self pair
      send_item(32'd7, 1'b0, 0);                     // repeated value, newest index wins
      send_item(32'd3, 1'b0, 0);
      send_item(32'd7, 1'b0, 0);
      send_item(32'hFFFF_FFF9, 1'b0, idle_gap());    // pair, rest of set ignored
      send_item(32'd9, 1'b1, idle_gap());            // last after pair: silent
      send_item(32'h8000_0000, 1'b0, idle_gap());    // sum wraps to zero, not a pair
      send_item(32'h8000_0000, 1'b1, idle_gap());

      // most positive target
      write_target(32'h7FFF_FFFF);
      send_item(32'd0, 1'b0, idle_gap());
      send_item(32'hFFFF_FFFF, 1'b0, idle_gap());
      send_item(32'h7FFF_FFFF, 1'b1, idle_gap());

      // most negative target: max + 1 wraps onto it but must not match
      write_target(32'h8000_0000);
      send_item(32'h7FFF_FFFF, 1'b0, 0);
      send_item(32'd1, 1'b0, 0);
      send_item(32'd0, 1'b0, 0);
      send_item(32'h8000_0000, 1'b1, idle_gap());

      // small negative target with a repeated partner
      write_target(32'hFFFF_FFFE);
      send_item(32'd3, 1'b0, idle_gap());
      send_item(32'd3, 1'b0, idle_gap());
      send_item(32'hFFFF_FFFB, 1'b1, idle_gap());

      // random phases, each under its own target
      phase_targets[0] = 32'h0000_0000;
      phase_targets[1] = 32'h7FFF_FFFF;
      phase_targets[2] = 32'h8000_0000;
      phase_targets[3] = DATA_BITS'($signed($urandom_range(0, 100)) - 50);
      phase_targets[4] = $urandom();
      phase_targets[5] = 32'd1;
      phase_targets[6] = 32'hFFFF_FFFF;
      phase_targets[7] = 32'd100;

      counted_items = 0;
      phase = 0;
      while (counted_items < RANDOM_ITEMS) begin
         write_target(phase_targets[phase % 8]);
         phase_start = counted_items;
         // every third phase opens with a set near or past the store size
         if (phase % 3 == 0)
            run_set($urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6), MODE_LONG,
                    $urandom_range(0, 3) == 0);
         while (counted_items - phase_start < PHASE_ITEMS && counted_items < RANDOM_ITEMS) begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_SMALL : MODE_FULL;
            run_set($urandom_range(1, 14), mode, $urandom_range(0, 3) == 0);
         end
         phase++;
      end

      // drain: all results in, then a lookup walk of quiet cycles
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d target settings in %0d cycles",
               sb.requests, targets_written, cycle_count);
      $display("results checked: %0d pairs, %0d no pair, %0d store overflow",
               sb.seen_by_status[STATUS_FOUND], sb.seen_by_status[STATUS_NONE],
               sb.seen_by_status[STATUS_OVERFLOW]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("pair_sum_index_finder_core_tb: done, clean");
      end else begin
         $display("pair_sum_index_finder_core_tb: done, errors");
      end
      $finish;
   end

endmodule
